>>> hdl/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared types and constants of the length-prefixed message deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfr_pkg;

   localparam int HDR_BYTES   = 16;
   localparam int HDR_BITS    = 8 * HDR_BYTES;
   localparam int HDR_CNT_W   = $clog2(HDR_BYTES);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] CSR_RAW_CODE  = 2'd0;
   localparam logic [1:0] CSR_PBUF_CODE = 2'd1;
   localparam logic [1:0] CSR_FBUF_CODE = 2'd2;

   localparam logic [1:0] PROTO_RAW  = 2'd0;
   localparam logic [1:0] PROTO_PBUF = 2'd1;
   localparam logic [1:0] PROTO_FBUF = 2'd2;

   localparam logic [31:0] RAW_CODE_RESET  = 32'd0;
   localparam logic [31:0] PBUF_CODE_RESET = 32'd1;
   localparam logic [31:0] FBUF_CODE_RESET = 32'd2;

   localparam logic [31:0] LEN_LIMIT = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_META    = 2'd1,
      KIND_PAYLOAD = 2'd2,
      KIND_ERROR   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_BAD_PROTO = 2'd0,
      ERR_TOO_LONG  = 2'd1,
      ERR_META_LONG = 2'd2
   } err_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  byte_value;
      logic [1:0]  proto_index;
      logic [31:0] meta_length;
      logic [31:0] message_length;
      err_type     error_code;
      logic        last;
   } result_type;

endpackage

>>> hdl/dfr_front.sv
// ----------------------------------------------------------------------------
// dfr_front
// Collects the header, checks it against the protocol codes and tags body
// bytes; one result record per producing byte goes to the result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic [7:0]          req_rx_byte,
   output logic                req_full,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   input  logic                q_full,
   output logic                rec_push,
   output dfr_pkg::result_type rec
);

   logic [31:0] raw_code_ff;
   logic [31:0] pbuf_code_ff;
   logic [31:0] fbuf_code_ff;

   logic [dfr_pkg::HDR_BITS-9:0]  hdr_ff,   hdr_in;
   logic [dfr_pkg::HDR_CNT_W-1:0] cnt_ff,   cnt_in;
   logic [31:0]                   remain_ff, remain_in;
   logic [31:0]                   pos_ff,   pos_in;
   logic [31:0]                   meta_ff,  meta_in;
   logic [31:0]                   len_ff,   len_in;
   logic [1:0]                    proto_ff, proto_in;

   logic [dfr_pkg::HDR_BITS-1:0] hdr_full;
   logic [31:0]                  hdr_code;
   logic [31:0]                  hdr_meta;
   logic [63:0]                  hdr_len;
   logic                         accept;
   logic                         too_long;

   assign accept   = req_push & ~q_full;
   assign req_full = q_full;

   assign hdr_full = {req_rx_byte, hdr_ff};
   assign hdr_code = hdr_full[31:0];
   assign hdr_meta = hdr_full[63:32];
   assign hdr_len  = hdr_full[127:64];
   assign too_long = (hdr_len[63:32] != 32'd0) || (hdr_len[31:0] == dfr_pkg::LEN_LIMIT);

   always_comb begin
      hdr_in    = hdr_ff;
      cnt_in    = cnt_ff;
      remain_in = remain_ff;
      pos_in    = pos_ff;
      meta_in   = meta_ff;
      len_in    = len_ff;
      proto_in  = proto_ff;
      rec_push  = 1'b0;
      rec       = '0;

      if (accept) begin
         if (remain_ff != 32'd0) begin
            rec_push           = 1'b1;
            rec.kind           = (pos_ff < meta_ff) ? dfr_pkg::KIND_META
                                                    : dfr_pkg::KIND_PAYLOAD;
            rec.byte_value     = req_rx_byte;
            rec.proto_index    = proto_ff;
            rec.meta_length    = meta_ff;
            rec.message_length = len_ff;
            rec.last           = (remain_ff == 32'd1);
            remain_in          = remain_ff - 32'd1;
            pos_in             = (remain_ff == 32'd1) ? 32'd0 : pos_ff + 32'd1;
         end else begin
            hdr_in = hdr_full[dfr_pkg::HDR_BITS-1:8];
            if (cnt_ff != dfr_pkg::HDR_CNT_W'(dfr_pkg::HDR_BYTES - 1)) begin
               cnt_in = cnt_ff + 1'b1;
            end else begin
               cnt_in   = '0;
               rec_push = 1'b1;
               rec.kind = dfr_pkg::KIND_ERROR;
               if (hdr_code == raw_code_ff) begin
                  rec.proto_index = dfr_pkg::PROTO_RAW;
               end else if (hdr_code == pbuf_code_ff) begin
                  rec.proto_index = dfr_pkg::PROTO_PBUF;
               end else begin
                  rec.proto_index = dfr_pkg::PROTO_FBUF;
               end
               if ((hdr_code != raw_code_ff) && (hdr_code != pbuf_code_ff)
                   && (hdr_code != fbuf_code_ff)) begin
                  rec.proto_index = '0;
                  rec.error_code  = dfr_pkg::ERR_BAD_PROTO;
               end else if (too_long) begin
                  rec.proto_index = '0;
                  rec.error_code  = dfr_pkg::ERR_TOO_LONG;
               end else if (hdr_meta > hdr_len[31:0]) begin
                  rec.proto_index = '0;
                  rec.error_code  = dfr_pkg::ERR_META_LONG;
               end else begin
                  rec.kind           = dfr_pkg::KIND_HEADER;
                  rec.meta_length    = hdr_meta;
                  rec.message_length = hdr_len[31:0];
                  rec.last           = (hdr_len[31:0] == 32'd0);
                  remain_in          = hdr_len[31:0];
                  pos_in             = 32'd0;
                  meta_in            = hdr_meta;
                  len_in             = hdr_len[31:0];
                  proto_in           = rec.proto_index;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
      len_ff <= len_in;
      if (reset) begin
         raw_code_ff  <= dfr_pkg::RAW_CODE_RESET;
         pbuf_code_ff <= dfr_pkg::PBUF_CODE_RESET;
         fbuf_code_ff <= dfr_pkg::FBUF_CODE_RESET;
         cnt_ff       <= '0;
         remain_ff    <= '0;
         pos_ff       <= '0;
         meta_ff      <= '0;
         proto_ff     <= '0;
      end else begin
         cnt_ff    <= cnt_in;
         remain_ff <= remain_in;
         pos_ff    <= pos_in;
         meta_ff   <= meta_in;
         proto_ff  <= proto_in;
         if (csr_we) begin
            unique case (csr_index)
               dfr_pkg::CSR_RAW_CODE:  raw_code_ff  <= csr_wdata;
               dfr_pkg::CSR_PBUF_CODE: pbuf_code_ff <= csr_wdata;
               dfr_pkg::CSR_FBUF_CODE: fbuf_code_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

>>> hdl/dfr_back.sv
// ----------------------------------------------------------------------------
// dfr_back
// Result queue: holds finished records and hands out the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                rec_push,
   input  dfr_pkg::result_type rec,
   output logic                q_full,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output dfr_pkg::result_type rsp_rec
);

   dfr_pkg::result_type mem_ff [dfr_pkg::QUEUE_DEPTH];

   logic [dfr_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dfr_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dfr_pkg::QCNT_W-1:0] cnt_ff,    cnt_in;
   logic                       do_push;
   logic                       do_pop;

   assign q_full    = (cnt_ff == dfr_pkg::QCNT_W'(dfr_pkg::QUEUE_DEPTH));
   assign rsp_empty = (cnt_ff == '0);
   assign rsp_rec   = mem_ff[rd_ptr_ff];
   assign do_push   = rec_push & ~q_full;
   assign do_pop    = rsp_pop & ~rsp_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == dfr_pkg::QPTR_W'(dfr_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == dfr_pkg::QPTR_W'(dfr_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= rec;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

>>> hdl/length_prefixed_message_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer
// Splits a byte stream into header records and tagged meta/payload bytes.
// ----------------------------------------------------------------------------
// Input side is a queue write port: a byte is taken on a clock edge with
// req_push high and req_full low. Result side is a queue read port: the
// oldest result sits on the rsp_ ports while rsp_empty is low and leaves on
// an edge with rsp_pop high. Protocol codes are written through csr_we,
// csr_index (0 raw, 1 protobuf, 2 flatbuffers) and csr_wdata; the user must
// do so only while idle; the block does not enforce it. The first 16 bytes
// of a frame form the header and give no result, except the last, which gives
// a header record or an error. Each body byte gives one meta or payload item;
// the final one has rsp_last set. A result is queued on the edge that takes
// its byte. One byte per cycle is sustained while req_full is low; the front
// end holds a byte counter, a length counter and the header compares, and
// feeds a two-entry result queue. req_full rises only when that queue is full,
// i.e. the reader has stalled for two result items. Synchronous reset empties
// the queue, restarts header collection and restores the codes to 0, 1 and 2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefixed_message_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_rx_byte,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_byte_value,
   output logic [1:0]  rsp_proto_index,
   output logic [31:0] rsp_meta_length,
   output logic [31:0] rsp_message_length,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic                q_full;
   logic                rec_push;
   dfr_pkg::result_type rec;
   dfr_pkg::result_type rsp_rec;

   dfr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_rx_byte (req_rx_byte),
      .req_full    (req_full),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_full      (q_full),
      .rec_push    (rec_push),
      .rec         (rec)
   );

   dfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_push  (rec_push),
      .rec       (rec),
      .q_full    (q_full),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_rec   (rsp_rec)
   );

   assign rsp_kind           = rsp_rec.kind;
   assign rsp_byte_value     = rsp_rec.byte_value;
   assign rsp_proto_index    = rsp_rec.proto_index;
   assign rsp_meta_length    = rsp_rec.meta_length;
   assign rsp_message_length = rsp_rec.message_length;
   assign rsp_error_code     = rsp_rec.error_code;
   assign rsp_last           = rsp_rec.last;

endmodule

>>> dv/length_prefixed_message_deframer_test.sv
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer_test
// Self-checking bench for the deframer: frames in, header/body items out.
// ----------------------------------------------------------------------------
// Bytes are pushed through the req_ queue port and each accepted byte runs
// through a deframing predictor; the items it yields wait in order and are
// compared field by field with what leaves the rsp_ port. A short table of
// frames covers the header checks, their order, empty and equal-code cases;
// then random phases of mostly well-formed frames with truncated headers,
// bad headers and noise run under several protocol code settings. Both sides
// idle at random, and once the reader stalls long enough to fill the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefixed_message_deframer_test;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 150;
   localparam int PHASE_BYTES    = 60;
   localparam int MAX_REPORTS    = 40;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic [7:0]  req_rx_byte;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_byte_value;
   logic [1:0]  rsp_proto_index;
   logic [31:0] rsp_meta_length;
   logic [31:0] rsp_message_length;
   logic [1:0]  rsp_error_code;
   logic        rsp_last;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   length_prefixed_message_deframer dut (.*);

   typedef struct packed {
      bit                set_codes;
      logic [31:0]       c0;
      logic [31:0]       c1;
      logic [31:0]       c2;
      logic [31:0]       code;
      logic [31:0]       meta;
      logic [63:0]       len;
      logic [7:0]        seed;
      bit                fixed;
      dfr_pkg::kind_type ek;
      dfr_pkg::err_type  ee;
      logic [1:0]        ep;
   } frame_row_type;

   // fixed rows carry the item expected when the header completes
   frame_row_type frame_rows [13] = '{
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 64'd0, 8'h00,
        1'b1, dfr_pkg::KIND_HEADER, dfr_pkg::ERR_BAD_PROTO, dfr_pkg::PROTO_RAW},
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 64'd3, 8'hFE,
        1'b0, dfr_pkg::KIND_HEADER, dfr_pkg::ERR_BAD_PROTO, dfr_pkg::PROTO_RAW},
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd2, 32'd2, 64'd2, 8'h7F,
        1'b0, dfr_pkg::KIND_HEADER, dfr_pkg::ERR_BAD_PROTO, dfr_pkg::PROTO_RAW},
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 64'd1, 8'hFF,
        1'b0, dfr_pkg::KIND_HEADER, dfr_pkg::ERR_BAD_PROTO, dfr_pkg::PROTO_RAW},
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd3, 32'd0, 64'd0, 8'h00,
        1'b1, dfr_pkg::KIND_ERROR, dfr_pkg::ERR_BAD_PROTO, dfr_pkg::PROTO_RAW},
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFF, 8'h00,
        1'b1, dfr_pkg::KIND_ERROR, dfr_pkg::ERR_BAD_PROTO, dfr_pkg::PROTO_RAW},
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 64'h0000_0000_FFFF_FFFF, 8'h00,
        1'b1, dfr_pkg::KIND_ERROR, dfr_pkg::ERR_TOO_LONG, dfr_pkg::PROTO_RAW},
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
        8'h00, 1'b1, dfr_pkg::KIND_ERROR, dfr_pkg::ERR_TOO_LONG, dfr_pkg::PROTO_RAW},
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd2, 32'hFFFF_FFFF, 64'h0000_0000_FFFF_FFFE,
        8'h00, 1'b1, dfr_pkg::KIND_ERROR, dfr_pkg::ERR_META_LONG, dfr_pkg::PROTO_RAW},
      '{1'b0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd5, 64'd4, 8'h00,
        1'b1, dfr_pkg::KIND_ERROR, dfr_pkg::ERR_META_LONG, dfr_pkg::PROTO_RAW},
      '{1'b1, 32'd5, 32'd5, 32'd5, 32'd5, 32'd0, 64'd0, 8'h00,
        1'b1, dfr_pkg::KIND_HEADER, dfr_pkg::ERR_BAD_PROTO, dfr_pkg::PROTO_RAW},
      '{1'b1, 32'd9, 32'd4, 32'd4, 32'd4, 32'd0, 64'd0, 8'h00,
        1'b1, dfr_pkg::KIND_HEADER, dfr_pkg::ERR_BAD_PROTO, dfr_pkg::PROTO_PBUF},
      '{1'b1, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'h8000_0000, 32'd0, 64'd2,
        8'h01, 1'b0, dfr_pkg::KIND_HEADER, dfr_pkg::ERR_BAD_PROTO, dfr_pkg::PROTO_RAW}
   };

   // deframing predictor state
   logic [7:0]  hdr_buf [dfr_pkg::HDR_BYTES];
   int          hdr_fill;
   logic [31:0] body_left;
   logic [31:0] body_pos;
   logic [31:0] cur_meta;
   logic [1:0]  cur_proto;
   logic [31:0] proto_code [3];

   dfr_pkg::result_type deframed_due [$];
   bit                  fixed_valid;
   dfr_pkg::result_type fixed_result;
   int                  mismatches;
   int                  bytes_sent;
   int                  idle_cycles;
   int                  pop_gap;
   bit                  steady;
   bit                  hold_request;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void deframe_byte(input logic [7:0] b, output bit produced,
                                        output dfr_pkg::result_type r);
      logic [31:0] code;
      logic [31:0] meta;
      logic [63:0] len;
      logic [1:0]  proto;
      int          i;
      r = '0;
      produced = 1'b0;
      if (body_left != 0) begin
         r.kind           = (body_pos < cur_meta) ? dfr_pkg::KIND_META
                                                  : dfr_pkg::KIND_PAYLOAD;
         r.byte_value     = b;
         r.proto_index    = cur_proto;
         r.meta_length    = cur_meta;
         r.message_length = body_pos + body_left;
         r.last           = (body_left == 32'd1);
         produced = 1'b1;
         body_left--;
         body_pos++;
         if (body_left == 0) body_pos = 0;
         return;
      end
      hdr_buf[hdr_fill] = b;
      hdr_fill++;
      if (hdr_fill < dfr_pkg::HDR_BYTES) return;
      hdr_fill = 0;
      produced = 1'b1;
      for (i = 0; i < 4; i++) begin
         code[8*i +: 8] = hdr_buf[i];
         meta[8*i +: 8] = hdr_buf[4 + i];
      end
      for (i = 0; i < 8; i++) len[8*i +: 8] = hdr_buf[8 + i];
      r.kind = dfr_pkg::KIND_ERROR;
      if (code == proto_code[0]) proto = dfr_pkg::PROTO_RAW;
      else if (code == proto_code[1]) proto = dfr_pkg::PROTO_PBUF;
      else if (code == proto_code[2]) proto = dfr_pkg::PROTO_FBUF;
      else begin
         r.error_code = dfr_pkg::ERR_BAD_PROTO;
         return;
      end
      if (len >= {32'd0, dfr_pkg::LEN_LIMIT}) begin
         r.error_code = dfr_pkg::ERR_TOO_LONG;
         return;
      end
      if ({32'd0, meta} > len) begin
         r.error_code = dfr_pkg::ERR_META_LONG;
         return;
      end
      r.kind           = dfr_pkg::KIND_HEADER;
      r.proto_index    = proto;
      r.meta_length    = meta;
      r.message_length = len[31:0];
      r.last           = (len == 0);
      body_left = len[31:0];
      body_pos  = 0;
      cur_meta  = meta;
      cur_proto = proto;
   endfunction

   task automatic flag_mismatch(input string field, input logic [63:0] got,
                                input logic [63:0] want);
      if (mismatches < MAX_REPORTS)
         $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
      mismatches++;
   endtask

   task automatic push_byte(input logic [7:0] b);
      bit                  produced;
      dfr_pkg::result_type r;
      int                  gap;
      req_push    <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_full);
      bytes_sent++;
      deframe_byte(b, produced, r);
      if (produced) begin
         if (fixed_valid) begin
            r = fixed_result;
            fixed_valid = 1'b0;
         end
         deframed_due.push_back(r);
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_header(input logic [31:0] code, input logic [31:0] meta,
                              input logic [63:0] len, input int count);
      int i;
      for (i = 0; i < count; i++) begin
         if (i < 4) push_byte(code[8*i +: 8]);
         else if (i < 8) push_byte(meta[8*(i-4) +: 8]);
         else push_byte(len[8*(i-8) +: 8]);
      end
   endtask

   task automatic go_idle();
      req_push <= 1'b0;
      while (deframed_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_codes(input logic [31:0] raw, input logic [31:0] pbuf,
                              input logic [31:0] fbuf);
      csr_we    <= 1'b1;
      csr_index <= dfr_pkg::CSR_RAW_CODE;
      csr_wdata <= raw;
      @(posedge clock);
      csr_index <= dfr_pkg::CSR_PBUF_CODE;
      csr_wdata <= pbuf;
      @(posedge clock);
      csr_index <= dfr_pkg::CSR_FBUF_CODE;
      csr_wdata <= fbuf;
      @(posedge clock);
      csr_we <= 1'b0;
      proto_code[0] = raw;
      proto_code[1] = pbuf;
      proto_code[2] = fbuf;
   endtask

   task automatic random_frame();
      logic [31:0] code;
      logic [31:0] meta;
      logic [63:0] len;
      int          roll;
      // finish any open body, close any open header with an error
      while (body_left != 0) push_byte(8'($urandom));
      while (hdr_fill != 0) push_byte(8'hFF);
      roll = $urandom_range(0, 99);
      code = proto_code[$urandom_range(0, 2)];
      roll = (roll < 70) ? 0 : (roll < 85) ? 1 : (roll < 93) ? 2 : 3;
      case (roll)
         0: begin
            len = ($urandom_range(0, 99) < 20) ? 64'd0 :
                  ($urandom_range(0, 99) < 80) ? 64'($urandom_range(1, 8)) :
                  64'($urandom_range(9, 48));
            meta = $urandom_range(0, len[31:0]);
            send_header(code, meta, len, dfr_pkg::HDR_BYTES);
            while (body_left != 0) push_byte(8'($urandom));
         end
         1: begin
            case ($urandom_range(0, 2))
               0: begin
                  code = $urandom;
                  meta = $urandom_range(0, 4);
                  len  = 64'(meta + $urandom_range(0, 4));
               end
               1: begin
                  meta = $urandom;
                  case ($urandom_range(0, 2))
                     0: len = 64'h0000_0000_FFFF_FFFF;
                     1: len = {$urandom, $urandom} | 64'h1_0000_0000;
                     default: len = 64'hFFFF_FFFF_FFFF_FFFF;
                  endcase
               end
               default: begin
                  len  = 64'($urandom_range(0, 8));
                  meta = $urandom_range(0, 1) ? len[31:0] + 32'd1 :
                         32'hFFFF_FFFF - $urandom_range(0, 255);
               end
            endcase
            send_header(code, meta, len, dfr_pkg::HDR_BYTES);
         end
         2: begin
            len  = 64'($urandom_range(0, 8));
            meta = $urandom_range(0, len[31:0]);
            send_header(code, meta, len, $urandom_range(1, dfr_pkg::HDR_BYTES - 1));
         end
         default: repeat ($urandom_range(1, dfr_pkg::HDR_BYTES - 1))
            push_byte(8'($urandom));
      endcase
   endtask

   // result checker
   always @(posedge clock) begin
      dfr_pkg::result_type want;
      if (reset === 1'b0 && rsp_pop && !rsp_empty) begin
         if (deframed_due.size() == 0) begin
            flag_mismatch("item with none due, kind", 64'(rsp_kind), 64'd0);
         end else begin
            want = deframed_due.pop_front();
            if (rsp_kind !== want.kind)
               flag_mismatch("kind", 64'(rsp_kind), 64'(want.kind));
            if (rsp_byte_value !== want.byte_value)
               flag_mismatch("byte_value", 64'(rsp_byte_value), 64'(want.byte_value));
            if (rsp_proto_index !== want.proto_index)
               flag_mismatch("proto_index", 64'(rsp_proto_index), 64'(want.proto_index));
            if (rsp_meta_length !== want.meta_length)
               flag_mismatch("meta_length", 64'(rsp_meta_length), 64'(want.meta_length));
            if (rsp_message_length !== want.message_length)
               flag_mismatch("message_length", 64'(rsp_message_length),
                             64'(want.message_length));
            if (rsp_error_code !== want.error_code)
               flag_mismatch("error_code", 64'(rsp_error_code), 64'(want.error_code));
            if (rsp_last !== want.last)
               flag_mismatch("last", 64'(rsp_last), 64'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset !== 1'b0 || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // reader
   initial begin
      rsp_pop = 1'b0;
      pop_gap = 0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_pop <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (pop_gap != 0) begin
            rsp_pop <= 1'b0;
            pop_gap--;
         end else begin
            rsp_pop <= 1'b1;
            pop_gap = pick_gap();
         end
      end
   end

   initial begin
      dfr_pkg::result_type r;
      logic [31:0]         c0;
      logic [31:0]         c1;
      logic [31:0]         c2;
      int                  k;
      int                  j;
      int                  ph;
      int                  phase_start;
      reset       = 1'b1;
      req_push    = 1'b0;
      req_rx_byte = 8'h00;
      csr_we      = 1'b0;
      csr_index   = dfr_pkg::CSR_RAW_CODE;
      csr_wdata   = 32'd0;
      mismatches  = 0;
      bytes_sent  = 0;
      steady      = 1'b0;
      hold_request = 1'b0;
      fixed_valid = 1'b0;
      hdr_fill    = 0;
      body_left   = 0;
      body_pos    = 0;
      cur_meta    = 0;
      cur_proto   = dfr_pkg::PROTO_RAW;
      proto_code[0] = dfr_pkg::RAW_CODE_RESET;
      proto_code[1] = dfr_pkg::PBUF_CODE_RESET;
      proto_code[2] = dfr_pkg::FBUF_CODE_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < $size(frame_rows); k++) begin
         if (frame_rows[k].set_codes) begin
            go_idle();
            write_codes(frame_rows[k].c0, frame_rows[k].c1, frame_rows[k].c2);
         end
         if (frame_rows[k].fixed) begin
            r = '0;
            r.kind       = frame_rows[k].ek;
            r.error_code = frame_rows[k].ee;
            if (frame_rows[k].ek == dfr_pkg::KIND_HEADER) begin
               r.proto_index    = frame_rows[k].ep;
               r.meta_length    = frame_rows[k].meta;
               r.message_length = frame_rows[k].len[31:0];
               r.last           = (frame_rows[k].len == 0);
            end
            fixed_result = r;
            fixed_valid  = 1'b1;
         end
         send_header(frame_rows[k].code, frame_rows[k].meta, frame_rows[k].len,
                     dfr_pkg::HDR_BYTES);
         for (j = 0; body_left != 0; j++) push_byte(8'(frame_rows[k].seed + j));
      end

      for (ph = 0; ph < 5; ph++) begin
         go_idle();
         case (ph)
            0: begin c0 = 32'd0; c1 = 32'd1; c2 = 32'd2; end
            1: begin c0 = 32'hFFFF_FFFF; c1 = 32'hFFFF_FFFE; c2 = 32'd0; end
            2: begin c0 = $urandom; c1 = $urandom; c2 = $urandom; end
            3: begin c0 = $urandom; c1 = c0; c2 = c0; end
            default: begin c0 = 32'd0; c1 = 32'd0; c2 = 32'hFFFF_FFFF; end
         endcase
         write_codes(c0, c1, c2);
         steady = (ph == 2);
         if (ph == 1) hold_request = 1'b1;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) random_frame();
      end
      steady = 1'b0;

      go_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
